FILE: rtl/core/mlp_backprop_trainer_assert.svh
// Assertion macros for the trainer core.
// Included by the RTL files that check their own sequencing; no other dependency.
`ifndef MLP_BACKPROP_TRAINER_ASSERT_SVH
`define MLP_BACKPROP_TRAINER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define MBT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MBT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/mbt_pkg.sv
// Shared types, codes and saturating helpers for the trainer core.
// No dependencies.
package mbt_pkg;

  typedef enum logic [1:0] {
    FUNC_TRAIN = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    CFG_LEARNING_RATE = 1'b0,
    CFG_RECIP_BATCH   = 1'b1
  } cfg_idx_e;

  localparam int unsigned UFRAC = 16;
  localparam int unsigned RomSize = 256;

  localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? SMIN : SMAX;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? SMIN : SMAX;
    return s[31:0];
  endfunction

endpackage

FILE: rtl/core/mbt_mul.sv
// Shared two-stage fixed-point multiplier with floor shift and saturation.
// Depends on mbt_pkg.
module mbt_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [32:0] b_i,
  input  logic               u16_i,
  output logic signed [31:0] res_o
);
  import mbt_pkg::*;

  logic signed [64:0] prod_q;
  logic               u16_q;
  logic signed [64:0] shifted;
  logic signed [31:0] res_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 65'(a_i) * 65'(b_i);
    u16_q  <= u16_i;
  end

  // arithmetic shift floors toward minus infinity
  assign shifted = u16_q ? (prod_q >>> UFRAC) : (prod_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (!shifted[64] && (|shifted[63:31])) begin
      res_q <= SMAX;
    end else if (shifted[64] && !(&shifted[63:31])) begin
      res_q <= SMIN;
    end else begin
      res_q <= shifted[31:0];
    end
  end

  assign res_o = res_q;
endmodule

FILE: rtl/core/mbt_sigmoid.sv
// Sigmoid lookup: 256-entry table over [-8,8) built at elaboration, saturating outside.
// Depends on mbt_pkg.
module mbt_sigmoid #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic signed [31:0] x_i,
  output logic signed [31:0] y_o
);
  import mbt_pkg::*;

  localparam logic [63:0] Q30One  = 64'd1073741824;
  localparam logic [63:0] ExpStep = 64'd1008687096;

  function automatic logic [63:0] exp_q30(int unsigned m);
    logic [63:0] ex;
    ex = Q30One;
    for (int unsigned j = 0; j < m; j++) begin
      ex = (ex * ExpStep + (Q30One >> 1)) >> 30;
    end
    return ex;
  endfunction

  logic [15:0] rom_w [RomSize];

  for (genvar k = 0; k < RomSize; k++) begin : g_rom
    localparam int unsigned M = (k < 128) ? (128 - k) : (k - 128);
    localparam logic [63:0] Ex  = exp_q30(M);
    localparam logic [63:0] Den = Q30One + Ex;
    localparam logic [63:0] Num = (k < 128) ? (Ex << 16) : (Q30One << 16);
    localparam logic [63:0] Quo = (Num + (Den >> 1)) / Den;
    assign rom_w[k] = (Quo > 64'd65535) ? 16'hFFFF : Quo[15:0];
  end

  logic signed [31:0] sh;
  logic [7:0]         idx;
  logic [15:0]        r;

  assign sh = x_i >>> (FRAC_BITS - 4);

  always_comb begin
    if (sh < -32'sd128) begin
      idx = 8'd0;
    end else if (sh > 32'sd127) begin
      idx = 8'd255;
    end else begin
      idx = sh[7:0] ^ 8'h80;
    end
  end

  assign r = rom_w[idx];

  if (FRAC_BITS >= 16) begin : g_up
    assign y_o = {16'b0, r} << (FRAC_BITS - 16);
  end else begin : g_dn
    assign y_o = {16'b0, r} >> (16 - FRAC_BITS);
  end
endmodule

FILE: rtl/core/mbt_store.sv
// Single-port-write, registered-read word store with per-entry valid bits (reads zero until written).
// Depends on mbt_pkg.
module mbt_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [31:0] rdata_o
);
  import mbt_pkg::*;

  logic signed [31:0] mem_q [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/mlp_backprop_trainer.sv
// Two-layer perceptron trainer, top level: sequencer, weight and gradient stores, shared multiplier.
// Depends on mbt_pkg, mbt_store, mbt_mul, mbt_sigmoid and mlp_backprop_trainer_assert.svh.
//
// Each training beat runs the forward pass, the gradient accumulation and, on an epoch end,
// the weight update as a chain of micro-operations through one shared multiplier. Every
// micro-operation passes through four states (store read, multiply, saturate, write-back). The
// input is stalled while a beat is in work; a finished result waits in the output register, so
// the next beat can be taken before it leaves.
`include "mlp_backprop_trainer_assert.svh"
module mlp_backprop_trainer #(
  parameter int unsigned INPUT_COUNT  = 3,
  parameter int unsigned HIDDEN_COUNT = 3,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] feature_a_i,
  input  logic signed [31:0] feature_b_i,
  input  logic signed [31:0] feature_c_i,
  input  logic signed [31:0] target_i,
  input  logic               epoch_end_i,
  input  logic [3:0]         weight_index_i,
  input  logic signed [31:0] weight_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] prediction_o,
  output logic signed [31:0] output_error_o,
  output logic signed [31:0] weight_read_o
);
  import mbt_pkg::*;

  localparam int unsigned IhCount     = INPUT_COUNT * HIDDEN_COUNT;
  localparam int unsigned HbBase      = IhCount;
  localparam int unsigned HoBase      = IhCount + HIDDEN_COUNT;
  localparam int unsigned ObSlot      = IhCount + 2 * HIDDEN_COUNT;
  localparam int unsigned WeightCount = ObSlot + 1;
  localparam int unsigned AW = $clog2(WeightCount);
  localparam int unsigned IW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int unsigned HW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam logic signed [31:0] OneFx = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_WAIT = 6'b001000,
    ST_POST = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    OP_FWD_OB, OP_FWD_IH, OP_FWD_HB, OP_FWD_HO, OP_ERR, OP_GOB, OP_T1, OP_T2,
    OP_HE, OP_GHB, OP_T3, OP_GHO, OP_T4, OP_GIH, OP_UPD, OP_RDW
  } op_e;

  state_e state_q;
  op_e    op_q;
  logic [IW-1:0] i_q;
  logic [HW-1:0] h_q;
  logic [AW-1:0] k_q;
  logic [AW-1:0] slot_q;
  logic          epoch_q;
  logic signed [31:0] x_q [INPUT_COUNT];
  logic signed [31:0] s_q [HIDDEN_COUNT];
  logic signed [31:0] target_q, act_q, acc_q, err_q, t_q, he_q;
  logic signed [31:0] pred_r_q, err_r_q, rd_r_q;
  logic [15:0] lr_q;
  logic [16:0] rb_q;
  logic        out_valid_q;
  logic signed [31:0] prediction_q, output_error_q, weight_read_q;

  logic accept, slot_ok, i_last, h_last, k_last, seq_done;
  logic [AW-1:0] ih_addr, w_addr, g_addr, w_waddr;
  logic w_re, w_we, g_we;
  logic signed [31:0] w_wdata, g_wdata, w_rd, g_rd, mul_res, sig_out, x_sel, s_sel;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic mul_u16;

  assign accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_ok = (32'(weight_index_i) < WeightCount);
  assign i_last  = (i_q == IW'(INPUT_COUNT - 1));
  assign h_last  = (h_q == HW'(HIDDEN_COUNT - 1));
  assign k_last  = (k_q == AW'(WeightCount - 1));
  assign x_sel   = x_q[i_q];
  assign s_sel   = s_q[h_q];
  assign ih_addr = AW'(AW'(h_q) * AW'(INPUT_COUNT) + AW'(i_q));

  // last micro-operation of the beat
  assign seq_done = (op_q == OP_RDW) ||
                    ((op_q == OP_GIH) && i_last && h_last && !epoch_q) ||
                    ((op_q == OP_UPD) && k_last);

  always_comb begin
    w_addr = ih_addr;
    g_addr = ih_addr;
    case (op_q)
      OP_FWD_OB: w_addr = AW'(ObSlot);
      OP_FWD_HB: w_addr = AW'(HbBase) + AW'(h_q);
      OP_FWD_HO, OP_HE: w_addr = AW'(HoBase) + AW'(h_q);
      OP_UPD:    w_addr = k_q;
      OP_RDW:    w_addr = slot_q;
      default:   w_addr = ih_addr;
    endcase
    case (op_q)
      OP_GOB:  g_addr = AW'(ObSlot);
      OP_GHB:  g_addr = AW'(HbBase) + AW'(h_q);
      OP_GHO:  g_addr = AW'(HoBase) + AW'(h_q);
      OP_UPD:  g_addr = k_q;
      default: g_addr = ih_addr;
    endcase
  end

  // multiplier operands per micro-operation
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_u16 = 1'b0;
    case (op_q)
      OP_FWD_IH: begin mul_a = x_sel;   mul_b = {w_rd[31], w_rd}; end
      OP_FWD_HO: begin mul_a = sig_out; mul_b = {w_rd[31], w_rd}; end
      OP_GOB:    begin mul_a = err_q;   mul_b = {16'b0, rb_q}; mul_u16 = 1'b1; end
      OP_T1: begin
        mul_a = s_sel;
        mul_b = {1'b0, OneFx - s_sel};
      end
      OP_T2:     begin mul_a = t_q;     mul_b = {err_q[31], err_q}; end
      OP_HE:     begin mul_a = t_q;     mul_b = {w_rd[31], w_rd}; end
      OP_GHB:    begin mul_a = he_q;    mul_b = {16'b0, rb_q}; mul_u16 = 1'b1; end
      OP_T3:     begin mul_a = err_q;   mul_b = {s_sel[31], s_sel}; end
      OP_GHO, OP_GIH: begin mul_a = t_q; mul_b = {16'b0, rb_q}; mul_u16 = 1'b1; end
      OP_T4:     begin mul_a = x_sel;   mul_b = {he_q[31], he_q}; end
      OP_UPD:    begin mul_a = g_rd;    mul_b = {17'b0, lr_q}; mul_u16 = 1'b1; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign w_re = (state_q == ST_READ);
  assign w_we = (accept && (func_e'(func_i) == FUNC_WRITE) && slot_ok) ||
                ((state_q == ST_POST) && (op_q == OP_UPD));
  assign w_waddr = (state_q == ST_IDLE) ? AW'(weight_index_i) : k_q;
  assign w_wdata = (state_q == ST_IDLE) ? weight_value_i : sat_sub(w_rd, mul_res);
  assign g_we = (state_q == ST_POST) && ((op_q == OP_GOB) || (op_q == OP_GHB) ||
                (op_q == OP_GHO) || (op_q == OP_GIH) || (op_q == OP_UPD));
  assign g_wdata = (op_q == OP_UPD) ? 32'sd0 : sat_add(g_rd, mul_res);

  mbt_store #(.DEPTH(WeightCount), .AW(AW)) u_wstore (
    .clk_i, .rst_ni, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(w_re), .raddr_i(w_addr), .rdata_o(w_rd)
  );

  mbt_store #(.DEPTH(WeightCount), .AW(AW)) u_gstore (
    .clk_i, .rst_ni, .we_i(g_we), .waddr_i(g_addr), .wdata_i(g_wdata),
    .re_i(w_re), .raddr_i(g_addr), .rdata_o(g_rd)
  );

  mbt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .a_i(mul_a), .b_i(mul_b), .u16_i(mul_u16), .res_o(mul_res)
  );

  mbt_sigmoid #(.FRAC_BITS(FRAC_BITS)) u_sig (
    .x_i(act_q), .y_o(sig_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= 16'd6554;
      rb_q <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEARNING_RATE: lr_q <= cfg_wdata_i[15:0];
        CFG_RECIP_BATCH:   rb_q <= cfg_wdata_i;
        default:           lr_q <= lr_q;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_FWD_OB;
      i_q     <= '0;
      h_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            i_q <= '0;
            h_q <= '0;
            k_q <= '0;
            unique case (func_e'(func_i))
              FUNC_TRAIN: begin op_q <= OP_FWD_OB; state_q <= ST_READ; end
              FUNC_READ: begin
                op_q    <= OP_RDW;
                state_q <= slot_ok ? ST_READ : ST_DONE;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_READ: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_WAIT;
        ST_WAIT: state_q <= ST_POST;
        ST_POST: begin
          state_q <= seq_done ? ST_DONE : ST_READ;
          case (op_q)
            OP_FWD_OB: op_q <= OP_FWD_IH;
            OP_FWD_IH: begin
              if (i_last) begin i_q <= '0; op_q <= OP_FWD_HB; end
              else i_q <= i_q + 1'b1;
            end
            OP_FWD_HB: op_q <= OP_FWD_HO;
            OP_FWD_HO: begin
              if (h_last) begin h_q <= '0; op_q <= OP_ERR; end
              else begin h_q <= h_q + 1'b1; op_q <= OP_FWD_IH; end
            end
            OP_ERR: op_q <= OP_GOB;
            OP_GOB: op_q <= OP_T1;
            OP_T1:  op_q <= OP_T2;
            OP_T2:  op_q <= OP_HE;
            OP_HE:  op_q <= OP_GHB;
            OP_GHB: op_q <= OP_T3;
            OP_T3:  op_q <= OP_GHO;
            OP_GHO: begin i_q <= '0; op_q <= OP_T4; end
            OP_T4:  op_q <= OP_GIH;
            OP_GIH: begin
              if (!i_last) begin
                i_q <= i_q + 1'b1;
                op_q <= OP_T4;
              end else begin
                i_q <= '0;
                if (!h_last) begin
                  h_q <= h_q + 1'b1;
                  op_q <= OP_T1;
                end else if (epoch_q) begin
                  k_q <= '0;
                  op_q <= OP_UPD;
                end
              end
            end
            OP_UPD: begin
              if (!k_last) k_q <= k_q + 1'b1;
            end
            default: op_q <= op_q;
          endcase
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int unsigned n = 0; n < INPUT_COUNT; n++) begin
        x_q[n] <= (n == 0) ? feature_a_i : (n == 1) ? feature_b_i :
                  (n == 2) ? feature_c_i : 32'sd0;
      end
      target_q <= target_i;
      epoch_q  <= epoch_end_i;
      slot_q   <= AW'(weight_index_i);
      act_q    <= '0;
      pred_r_q <= '0;
      err_r_q  <= '0;
      rd_r_q   <= '0;
    end else if (state_q == ST_POST) begin
      case (op_q)
        OP_FWD_OB: acc_q <= w_rd;
        OP_FWD_IH: act_q <= sat_add(act_q, mul_res);
        OP_FWD_HB: act_q <= sat_add(act_q, w_rd);
        OP_FWD_HO: begin
          s_q[h_q] <= sig_out;
          acc_q    <= sat_add(acc_q, mul_res);
          act_q    <= '0;
        end
        OP_ERR: begin
          err_q    <= sat_sub(acc_q, target_q);
          pred_r_q <= acc_q;
          err_r_q  <= sat_sub(acc_q, target_q);
        end
        OP_T1, OP_T2, OP_T3, OP_T4: t_q <= mul_res;
        OP_HE:  he_q   <= mul_res;
        OP_RDW: rd_r_q <= w_rd;
        default: t_q   <= t_q;
      endcase
    end
  end

  // output register: load on completion, drop when out_stall_i is low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
      prediction_q   <= pred_r_q;
      output_error_q <= err_r_q;
      weight_read_q  <= rd_r_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign prediction_o   = prediction_q;
  assign output_error_o = output_error_q;
  assign weight_read_o  = weight_read_q;

  `MBT_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
  `MBT_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE)
  `MBT_ASSERT_IMP(a_post_after_wait, state_q == ST_POST, $past(state_q) == ST_WAIT)
endmodule
